// File: rtl/vwd_pkg.sv
package vwd_pkg;

   localparam int NUM_FIELDS     = 8;
   localparam int FIELD_W        = 32;
   localparam int VTX_W          = NUM_FIELDS * FIELD_W;
   localparam int IDX_OUT_W      = 10;
   localparam int MAX_UNIQUE_DEF = 1024;

   // field 0 (pos_x) in the lowest word, tex_v in the highest
   typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] vtx_type;

endpackage

// File: rtl/vwd_store.sv
module vwd_store import vwd_pkg::*; #(
   parameter int DEPTH = MAX_UNIQUE_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  vtx_type           wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output vtx_type           rd_data
);

   vtx_type mem [DEPTH];
   vtx_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/vwd_match.sv
module vwd_match import vwd_pkg::*; (
   input  vtx_type stored,
   input  vtx_type probe,
   output logic    match
);

   logic [NUM_FIELDS-1:0] field_eq;

   // float equality per field: NaN never equal, +0 equals -0
   always_comb begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         if ((stored[f][30:0] > 31'h7F80_0000) || (probe[f][30:0] > 31'h7F80_0000)) begin
            field_eq[f] = 1'b0;
         end else if ((stored[f][30:0] | probe[f][30:0]) == 31'd0) begin
            field_eq[f] = 1'b1;
         end else begin
            field_eq[f] = (stored[f] == probe[f]);
         end
      end
   end

   assign match = &field_eq;

endmodule

// File: rtl/vertex_weld_dedup_unit.sv
// Vertex welder: turns a stream of vertices into an index buffer.
// req_ channel: one vertex per transfer, eight IEEE single fields in
// req_tdata, req_tlast marks the final vertex of a mesh.
// rsp_ channel: one result per vertex; the index of the first matching
// stored vertex, or the newly appended index with is_new set, or
// overflow when the store is full and nothing matches. For a new vertex
// its fields are echoed, otherwise those bits are zero.
// A miss scans every unique vertex held for the current mesh before the
// result is decided (none with an empty store); a hit on entry k ends the
// scan once entry k has been read and compared.
// The scan reads one stored vertex per cycle from a single read port of the
// vertex memory, so a miss on a full store reads all MAX_UNIQUE entries; the
// next vertex is taken once the result is registered and the block is back
// in its idle step. One vertex is in work at a time.
// A finished result sits in the output register; the next vertex is taken
// while it waits, and the block holds in its final step while the receiver
// stalls. Reset empties the store at once (count cleared, memory contents
// are left as they are); a last-marked vertex empties it after its result.
module vertex_weld_dedup_unit import vwd_pkg::*; #(
   parameter int MAX_UNIQUE = MAX_UNIQUE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
   input  logic [255:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // unique_idx[9:0], out_pos_x, out_pos_y, out_pos_z, out_norm_x,
   // out_norm_y, out_norm_z, out_tex_u, out_tex_v, zero pad [271:266]
   output logic [271:0] rsp_tdata,
   // is_new, overflow
   output logic [1:0]   rsp_tuser
);

   localparam int IDX_W = $clog2(MAX_UNIQUE);
   localparam int CNT_W = $clog2(MAX_UNIQUE + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   vtx_type          vtx_ff, vtx_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rv_ff, rv_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic             res_hit_ff, res_hit_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   vtx_type              rsp_vtx_ff, rsp_vtx_in;

   logic             req_accept;
   logic             rd_en;
   vtx_type          rd_data;
   logic             match;
   logic             decide_hit, decide_miss;
   logic             finish;
   logic             full;
   logic             res_new;
   logic [IDX_W-1:0] res_index;
   logic [IDX_W+IDX_OUT_W-1:0] index_ext;
   logic             wr_en;

   vwd_store #(
      .DEPTH (MAX_UNIQUE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (vtx_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   vwd_match u_match (
      .stored (rd_data),
      .probe  (vtx_ff),
      .match  (match)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rd_en       = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign decide_hit  = (state_ff == ST_SCAN) && rv_ff && match;
   assign decide_miss = (state_ff == ST_SCAN) && !rv_ff && !rd_en;
   assign finish      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign full      = (count_ff == CNT_W'(MAX_UNIQUE));
   assign res_new   = !res_hit_ff && !full;
   assign res_index = res_hit_ff ? res_idx_ff :
                      (res_new ? count_ff[IDX_W-1:0] : '0);
   assign index_ext = {{IDX_OUT_W{1'b0}}, res_index};
   assign wr_en     = finish && res_new;

   always_comb begin
      state_in   = state_ff;
      vtx_in     = vtx_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      issue_in   = issue_ff;
      rv_in      = 1'b0;
      ridx_in    = ridx_ff;
      res_hit_in = res_hit_ff;
      res_idx_in = res_idx_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_vtx_in   = rsp_vtx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               vtx_in   = vtx_type'(req_tdata);
               last_in  = req_tlast;
               issue_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one read in flight; compare it while the next address goes out
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
               ridx_in  = issue_ff[IDX_W-1:0];
            end
            if (decide_hit) begin
               res_hit_in = 1'b1;
               res_idx_in = ridx_ff;
               state_in   = ST_DONE;
            end else if (decide_miss) begin
               res_hit_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               rv_in = rd_en;
            end
         end
         ST_DONE: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = index_ext[IDX_OUT_W-1:0];
               rsp_new_in   = res_new;
               rsp_ovf_in   = !res_hit_ff && full;
               rsp_vtx_in   = res_new ? vtx_ff : '0;
               if (last_ff) begin
                  count_in = '0;
               end else if (res_new) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vtx_ff     <= vtx_in;
      last_ff    <= last_in;
      issue_ff   <= issue_in;
      ridx_ff    <= ridx_in;
      res_hit_ff <= res_hit_in;
      res_idx_ff <= res_idx_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_new_ff <= rsp_new_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_vtx_ff <= rsp_vtx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_vtx_ff, rsp_idx_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_new_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_UNIQUE))
      else $error("unique count above store depth");

   a_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && (rsp_tdata[9:0] == 10'd0))
      else $error("overflow result with index or new flag");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      finish && last_ff |=> count_ff == '0)
      else $error("store not emptied after last vertex");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == ST_SCAN)
      else $error("read data pending outside of scan");

endmodule
